### rtl/tiad_pkg.sv
package tiad_pkg;

    // Default table size and register reset values
    localparam int TABLE_DEPTH_DEF = 64;
    localparam logic [15:0] MIN_INTERVAL_RST = 16'd5000;
    localparam logic [5:0] MISS_LIMIT_RST = 6'd30;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT = 1'b1;

    // Input command codes
    localparam logic CMD_DETECT = 1'b0;
    localparam logic CMD_EOF = 1'b1;

    // Frame status codes
    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_INIT = 2'd2;

    typedef struct packed {
        logic               command;
        logic signed [15:0] det_id;
        logic               is_person;
        logic               in_region;
        logic [47:0]        frame_time_ms;
    } tiad_in_t;

    typedef struct packed {
        logic [1:0] frame_status;
        logic       upload;
        logic [6:0] person_count;
        logic [6:0] reported_count;
        logic       table_overflow;
    } tiad_out_t;

    // One table entry as stored in the memory
    typedef struct packed {
        logic        valid;
        logic [14:0] id;
        logic [6:0]  miss;
        logic        reported;
        logic        seen;
    } tiad_entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_LK_RD,
        ST_LK_EV,
        ST_LK_INS,
        ST_AGE_RD,
        ST_AGE_EV,
        ST_UPD_CHK,
        ST_MARK_RD,
        ST_MARK_EV,
        ST_FIN,
        ST_OUT
    } tiad_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       clr_wr;
        logic       load_in;
        logic       note_det;
        logic       pass_start;
        logic       idx_clr;
        logic       idx_inc;
        logic       mem_rd;
        logic       lk_eval;
        logic       lk_insert;
        logic       age_eval;
        logic       upd_check;
        logic       mark_eval;
        logic       fin;
        logic [1:0] fin_code;
        logic       out_load;
    } tiad_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic eof;
        logic det_skip;
        logic had_det;
        logic init_pending;
        logic idx_last;
        logic lk_hit;
        logic out_free;
    } tiad_sts_t;

endpackage

### rtl/tiad_ctrl.sv
module tiad_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tiad_pkg::tiad_sts_t sts,
    output tiad_pkg::tiad_cmd_t cmd
);
    import tiad_pkg::*;

    tiad_state_t state_reg, state_next;

    // State register; reset starts the table clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.idx_last) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cmd.pass_start = 1'b1;
                if (!sts.eof) begin
                    cmd.note_det = 1'b1;
                    state_next = sts.det_skip ? ST_IDLE : ST_LK_RD;
                end else if (!sts.had_det) begin
                    cmd.fin = 1'b1;
                    cmd.fin_code = STATUS_IGNORED;
                    state_next = ST_OUT;
                end else if (sts.init_pending) begin
                    cmd.fin = 1'b1;
                    cmd.fin_code = STATUS_INIT;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_AGE_RD;
                end
            end
            ST_LK_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_LK_EV;
            end
            ST_LK_EV: begin
                cmd.lk_eval = 1'b1;
                if (sts.lk_hit) begin
                    state_next = ST_IDLE;
                end else if (sts.idx_last) begin
                    state_next = ST_LK_INS;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next = ST_LK_RD;
                end
            end
            ST_LK_INS: begin
                cmd.lk_insert = 1'b1;
                state_next = ST_IDLE;
            end
            ST_AGE_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_AGE_EV;
            end
            ST_AGE_EV: begin
                cmd.age_eval = 1'b1;
                if (sts.idx_last) begin
                    state_next = ST_UPD_CHK;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next = ST_AGE_RD;
                end
            end
            ST_UPD_CHK: begin
                cmd.upd_check = 1'b1;
                cmd.idx_clr = 1'b1;
                state_next = ST_MARK_RD;
            end
            ST_MARK_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_MARK_EV;
            end
            ST_MARK_EV: begin
                cmd.mark_eval = 1'b1;
                if (sts.idx_last) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next = ST_MARK_RD;
                end
            end
            ST_FIN: begin
                cmd.fin = 1'b1;
                cmd.fin_code = STATUS_DONE;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/tiad_dp.sv
module tiad_dp #(
    parameter int TABLE_DEPTH = tiad_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tiad_pkg::tiad_cmd_t               cmd,
    output tiad_pkg::tiad_sts_t               sts,
    input  tiad_pkg::tiad_in_t                s_data,
    input  logic                              cfg_valid,
    input  logic [tiad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tiad_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              m_ready,
    output logic                              m_valid,
    output tiad_pkg::tiad_out_t               m_data
);
    import tiad_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Entry table
    tiad_entry_t mem [TABLE_DEPTH];
    tiad_entry_t rd_data_reg;
    tiad_entry_t wr_data;
    logic [IDX_W-1:0] wr_addr;
    logic wr_en;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic free_found_reg;

    tiad_in_t in_reg;

    logic [15:0] min_interval_reg;
    logic [5:0] miss_limit_reg;

    logic [47:0] last_upload_reg;
    logic init_pending_reg;
    logic had_det_reg;
    logic overflow_reg;
    logic has_new_reg;
    logic upload_reg;
    logic ovf_out_reg;
    logic [1:0] res_status_reg;
    logic [CNT_W-1:0] person_cnt_reg;
    logic [CNT_W-1:0] reported_cnt_reg;

    logic m_valid_reg;
    tiad_out_t m_data_reg;

    logic lk_hit;
    logic [6:0] miss_inc;
    logic age_drop;
    logic [47:0] elapsed;
    logic [6:0] person_sat;
    logic [6:0] reported_sat;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_interval_reg <= MIN_INTERVAL_RST;
            miss_limit_reg <= MISS_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                CFG_MISS_LIMIT:   miss_limit_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Input transaction register
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
    end

    // Table walk index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.pass_start || cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Entry evaluation
    assign lk_hit = rd_data_reg.valid && (rd_data_reg.id == in_reg.det_id[14:0]);
    assign miss_inc = rd_data_reg.miss + 7'd1;
    assign age_drop = miss_inc > {1'b0, miss_limit_reg};
    assign elapsed = in_reg.frame_time_ms - last_upload_reg;

    // Table write select
    always_comb begin
        wr_en = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data_reg;
        if (cmd.clr_wr) begin
            wr_en = 1'b1;
            wr_data = '0;
        end else if (cmd.lk_eval && lk_hit) begin
            wr_en = 1'b1;
            wr_data.seen = 1'b1;
        end else if (cmd.lk_insert && free_found_reg) begin
            wr_en = 1'b1;
            wr_addr = free_idx_reg;
            wr_data.valid = 1'b1;
            wr_data.id = in_reg.det_id[14:0];
            wr_data.miss = '0;
            wr_data.reported = 1'b0;
            wr_data.seen = 1'b1;
        end else if (cmd.age_eval && rd_data_reg.valid) begin
            wr_en = 1'b1;
            if (rd_data_reg.seen) begin
                wr_data.miss = '0;
            end else if (age_drop) begin
                wr_data.valid = 1'b0;
                wr_data.reported = 1'b0;
                wr_data.miss = '0;
            end else begin
                wr_data.miss = miss_inc;
            end
        end else if (cmd.mark_eval && rd_data_reg.valid && rd_data_reg.seen) begin
            wr_en = 1'b1;
            wr_data.seen = 1'b0;
            if (upload_reg) begin
                wr_data.reported = 1'b1;
                wr_data.miss = '0;
            end
        end
    end

    // Table memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Lowest free slot seen during a lookup walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_found_reg <= 1'b0;
        end else if (cmd.pass_start) begin
            free_found_reg <= 1'b0;
        end else if (cmd.lk_eval && !rd_data_reg.valid && !free_found_reg) begin
            free_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lk_eval && !rd_data_reg.valid && !free_found_reg) begin
            free_idx_reg <= idx_reg;
        end
    end

    // Frame state flags and upload timing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_pending_reg <= 1'b1;
            had_det_reg <= 1'b0;
            overflow_reg <= 1'b0;
            last_upload_reg <= '0;
            has_new_reg <= 1'b0;
            upload_reg <= 1'b0;
            ovf_out_reg <= 1'b0;
            res_status_reg <= STATUS_DONE;
            person_cnt_reg <= '0;
        end else begin
            if (cmd.note_det) begin
                had_det_reg <= 1'b1;
            end
            if (cmd.lk_insert && !free_found_reg) begin
                overflow_reg <= 1'b1;
            end
            // person count also starts from zero for ignored and first frames
            if (cmd.pass_start) begin
                has_new_reg <= 1'b0;
                person_cnt_reg <= '0;
            end
            if (cmd.age_eval && rd_data_reg.valid && rd_data_reg.seen) begin
                person_cnt_reg <= person_cnt_reg + 1'b1;
                if (!rd_data_reg.reported) begin
                    has_new_reg <= 1'b1;
                end
            end
            if (cmd.upd_check) begin
                upload_reg <= has_new_reg && (elapsed >= {32'd0, min_interval_reg});
                if (has_new_reg && (elapsed >= {32'd0, min_interval_reg})) begin
                    last_upload_reg <= in_reg.frame_time_ms;
                end
            end
            if (cmd.fin) begin
                res_status_reg <= cmd.fin_code;
                had_det_reg <= 1'b0;
                overflow_reg <= 1'b0;
                if (cmd.fin_code == STATUS_DONE) begin
                    ovf_out_reg <= overflow_reg;
                end else begin
                    ovf_out_reg <= 1'b0;
                    upload_reg <= 1'b0;
                end
                if (cmd.fin_code == STATUS_INIT) begin
                    last_upload_reg <= in_reg.frame_time_ms;
                    init_pending_reg <= 1'b0;
                end
            end
        end
    end

    // Count of valid entries marked reported
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reported_cnt_reg <= '0;
        end else if (cmd.age_eval && rd_data_reg.valid && !rd_data_reg.seen && age_drop
                     && rd_data_reg.reported) begin
            reported_cnt_reg <= reported_cnt_reg - 1'b1;
        end else if (cmd.mark_eval && upload_reg && rd_data_reg.valid && rd_data_reg.seen
                     && !rd_data_reg.reported) begin
            reported_cnt_reg <= reported_cnt_reg + 1'b1;
        end
    end

    // Saturate counts to the 7-bit result fields
    assign person_sat = (32'(person_cnt_reg) > 32'd127) ? 7'd127 : 7'(person_cnt_reg);
    assign reported_sat = (32'(reported_cnt_reg) > 32'd127) ? 7'd127 : 7'(reported_cnt_reg);

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.frame_status <= res_status_reg;
            m_data_reg.upload <= upload_reg;
            m_data_reg.person_count <= person_sat;
            m_data_reg.reported_count <= reported_sat;
            m_data_reg.table_overflow <= ovf_out_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    // Status to the controller
    assign sts.eof = (in_reg.command == CMD_EOF);
    assign sts.det_skip = init_pending_reg || !in_reg.is_person || in_reg.det_id[15]
                          || !in_reg.in_region;
    assign sts.had_det = had_det_reg;
    assign sts.init_pending = init_pending_reg;
    assign sts.idx_last = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign sts.lk_hit = lk_hit;
    assign sts.out_free = !m_valid_reg || m_ready;

endmodule

### rtl/tracked_id_alert_dedup_unit.sv
// Channel  Ports                               Direction  Content
// -------  ----------------------------------  ---------  ---------------------------------
// input    s_valid, s_ready, s_data            in         detection or end-of-frame item
// result   m_valid, m_ready, m_data            out        one frame result per end of frame
// config   cfg_valid, cfg_ready, cfg_index,    in         0 upload interval, 1 miss limit
//          cfg_data
//
// In a detection the table memory is walked one entry at a time (registered read, then
// compare and write back), stopping on a match.
// An end of frame with detections walks the table twice (ageing walk, then mark walk),
// except in the first frame; other end-of-frame items do not walk the table.
// After reset every table entry is cleared before s_ready rises.
// Reset is synchronous, active low. A result waiting on m_ready holds the block before
// its next result only; cfg_ready is always high.
module tracked_id_alert_dedup_unit #(
    parameter int TABLE_DEPTH = tiad_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tiad_pkg::tiad_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tiad_pkg::tiad_out_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tiad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tiad_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tiad_pkg::*;

    tiad_cmd_t cmd;
    tiad_sts_t sts;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    // Sequencer
    tiad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table, counters and result register
    tiad_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

### rtl/tiad_checker.sv
module tiad_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input tiad_pkg::tiad_out_t m_data
);
    import tiad_pkg::*;

    // A stalled result holds its contents
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // One item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous item in work");

    // Ignored and first frames report no upload, persons or overflow
    a_quiet_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.frame_status != STATUS_DONE) |->
            !m_data.upload && (m_data.person_count == 7'd0) && !m_data.table_overflow)
        else $error("non-processed frame carries activity");

    // An upload needs a seen person and leaves at least one entry reported
    a_upload_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.upload |->
            (m_data.person_count != 7'd0) && (m_data.reported_count != 7'd0))
        else $error("upload without seen or reported entries");

endmodule

bind tracked_id_alert_dedup_unit tiad_checker u_tiad_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
